@@ design/bmxq_pkg.sv @@
package bmxq_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 31;

	localparam int STATUS_BITS = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_ANSWER   = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_NONE     = 2'd3;

	typedef struct packed {
		logic clear;
		logic valid;
	} acc_ctl_t;

endpackage

@@ design/bmxq_best.sv @@
module bmxq_best #(
	parameter int VALUE_BITS = bmxq_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bmxq_pkg::acc_ctl_t     ctl,
	input  logic [VALUE_BITS-1:0]  data,
	input  logic [VALUE_BITS-1:0]  key,
	input  logic [VALUE_BITS-1:0]  limit,
	output logic                   found,
	output logic [VALUE_BITS-1:0]  best
);
	import bmxq_pkg::*;

	logic                  found_q;
	logic [VALUE_BITS-1:0] best_q;
	logic [VALUE_BITS-1:0] cand;
	logic                  in_lim;
	logic                  take;

	assign cand   = data ^ key;
	assign in_lim = (data <= limit);
	assign take   = ctl.valid && in_lim && (!found_q || (cand > best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.valid && in_lim) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= cand;
		end
	end

	assign found = found_q;
	assign best  = best_q;

endmodule

@@ design/bounded_max_xor_query.sv @@
// Insert: the result goes to the output register, or to the holding slot while that
// register is occupied. Query: an empty store answers ST_NONE with no scan; else
// the scan reads the value memory through its single read port, one entry per cycle.
// One item is in work at a time; a finished result waits in the output register
// while the next word is taken.
// Reset clears the entry count and all control state; memory contents are not cleared.
module bounded_max_xor_query #(
	parameter int CAPACITY   = bmxq_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = bmxq_pkg::VALUE_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// value, limit
	input  logic [((2*VALUE_BITS+7)/8)*8-1:0]           s_tdata,
	// cmd
	input  logic                                        s_tuser,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// best_xor
	output logic [((VALUE_BITS+7)/8)*8-1:0]             m_tdata,
	// status
	output logic [bmxq_pkg::STATUS_BITS-1:0]            m_tuser
);
	import bmxq_pkg::*;

	localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int OUT_DW = ((VALUE_BITS + 7) / 8) * 8;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TAIL = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [VALUE_BITS-1:0] mem [CAPACITY];

	logic [2:0]             state_q;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          scan_q;
	logic [AW-1:0]          last_idx;
	logic                   rd_valid_s1;
	logic [VALUE_BITS-1:0]  rd_data_s1;
	logic [VALUE_BITS-1:0]  key_q;
	logic [VALUE_BITS-1:0]  limit_q;

	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] out_status_q;
	logic [VALUE_BITS-1:0]  out_data_q;
	logic [STATUS_BITS-1:0] pend_status_q;
	logic [VALUE_BITS-1:0]  pend_data_q;

	logic                   s_accept;
	logic                   is_insert;
	logic                   full;
	logic                   empty;
	logic                   out_free;
	logic                   fin_valid;
	logic [STATUS_BITS-1:0] fin_status;
	logic [VALUE_BITS-1:0]  fin_data;
	logic [VALUE_BITS-1:0]  in_value;
	logic [VALUE_BITS-1:0]  in_limit;

	acc_ctl_t               acc_ctl;
	logic                   acc_found;
	logic [VALUE_BITS-1:0]  acc_best;

	assign in_value  = s_tdata[VALUE_BITS-1:0];
	assign in_limit  = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
	assign s_tready  = (state_q == S_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign is_insert = (s_tuser == CMD_INSERT);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign out_free  = !out_valid_q || m_tready;
	assign last_idx  = AW'(count_q - CW'(1));

	// finished result of this cycle, if any
	always_comb begin
		fin_valid  = 1'b0;
		fin_status = ST_INSERTED;
		fin_data   = '0;
		if (s_accept && is_insert) begin
			fin_valid  = 1'b1;
			fin_status = full ? ST_FULL : ST_INSERTED;
		end else if (s_accept && empty) begin
			fin_valid  = 1'b1;
			fin_status = ST_NONE;
		end else if (state_q == S_FIN) begin
			fin_valid  = 1'b1;
			fin_status = acc_found ? ST_ANSWER : ST_NONE;
			fin_data   = acc_found ? acc_best : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (is_insert) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= out_free ? S_IDLE : S_WAIT;
						end else if (empty) begin
							state_q <= out_free ? S_IDLE : S_WAIT;
						end else begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + AW'(1);
					if (scan_q == last_idx) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= out_free ? S_IDLE : S_WAIT;
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// value memory: write on insert, read during the scan
	always_ff @(posedge clk) begin
		if (s_accept && is_insert && !full) begin
			mem[count_q[AW-1:0]] <= in_value;
		end
		rd_data_s1 <= mem[scan_q];
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			key_q   <= in_value;
			limit_q <= in_limit;
		end
	end

	assign acc_ctl.clear = s_accept;
	assign acc_ctl.valid = rd_valid_s1;

	bmxq_best #(
		.VALUE_BITS(VALUE_BITS)
	) u_best (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (acc_ctl),
		.data  (rd_data_s1),
		.key   (key_q),
		.limit (limit_q),
		.found (acc_found),
		.best  (acc_best)
	);

	// output register, with a holding slot when it is still occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((fin_valid || state_q == S_WAIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_valid && out_free) begin
			out_status_q <= fin_status;
			out_data_q   <= fin_data;
		end else if (state_q == S_WAIT && out_free) begin
			out_status_q <= pend_status_q;
			out_data_q   <= pend_data_q;
		end
		if (fin_valid && !out_free) begin
			pend_status_q <= fin_status;
			pend_data_q   <= fin_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_DW'(out_data_q);

endmodule

@@ design/bmxq_check.sv @@
module bmxq_check #(
	parameter int VALUE_BITS = bmxq_pkg::VALUE_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [((VALUE_BITS+7)/8)*8-1:0]      m_tdata,
	input logic [bmxq_pkg::STATUS_BITS-1:0]     m_tuser
);
	import bmxq_pkg::*;

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// only an answered query carries a nonzero xor
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_ANSWER) |-> (m_tdata == '0))
		else $error("nonzero data on a result that is not an answer");

	// an insert taken with a free output shows up in the next cycle
	a_insert_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == CMD_INSERT) && (!m_tvalid || m_tready) |=>
		m_tvalid && ((m_tuser == ST_INSERTED) || (m_tuser == ST_FULL)))
		else $error("insert result missing or wrong status");

	// a query on a nonempty store keeps the input closed while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == CMD_QUERY) && (!m_tvalid || m_tready) |=>
		!s_tready || (m_tvalid && (m_tuser == ST_NONE)))
		else $error("input taken during a query scan");

endmodule

bind bounded_max_xor_query bmxq_check #(
	.VALUE_BITS(VALUE_BITS)
) u_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ sim/bounded_max_xor_query_tb.sv @@
module bounded_max_xor_query_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmxq_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int VB           = VALUE_BITS_DEF;
	localparam int IN_W         = ((2*VB+7)/8)*8;
	localparam int OUT_W        = ((VB+7)/8)*8;
	localparam int RAND_ITEMS   = 550;
	localparam int HOLD_STRETCH = 300;
	localparam int STALL_LIMIT  = 20000;

	localparam logic [VB-1:0] VMAX = '1;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [VB-1:0]          best_xor;
	} xor_result_t;

	typedef struct packed {
		logic                   cmd;
		logic [VB-1:0]          val;
		logic [VB-1:0]          lim;
		logic                   fixed;
		logic [STATUS_BITS-1:0] status;
		logic [VB-1:0]          best_xor;
	} script_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{CMD_QUERY,  31'd0,          VMAX,           1'b1, ST_NONE,     31'd0},
		'{CMD_QUERY,  VMAX,           31'd0,          1'b1, ST_NONE,     31'd0},
		'{CMD_INSERT, 31'h100,        31'd0,          1'b1, ST_INSERTED, 31'd0},
		// every stored value above the limit
		'{CMD_QUERY,  31'd0,          31'hFF,         1'b1, ST_NONE,     31'd0},
		'{CMD_QUERY,  31'd0,          31'h100,        1'b1, ST_ANSWER,   31'h100},
		'{CMD_INSERT, 31'd0,          VMAX,           1'b1, ST_INSERTED, 31'd0},
		'{CMD_INSERT, VMAX,           VMAX,           1'b1, ST_INSERTED, 31'd0},
		'{CMD_QUERY,  31'd0,          VMAX,           1'b1, ST_ANSWER,   VMAX},
		'{CMD_QUERY,  VMAX,           VMAX,           1'b1, ST_ANSWER,   VMAX},
		'{CMD_QUERY,  VMAX,           31'd0,          1'b1, ST_ANSWER,   VMAX},
		'{CMD_QUERY,  31'd0,          31'd0,          1'b1, ST_ANSWER,   31'd0},
		'{CMD_QUERY,  VMAX,           VMAX - 31'd1,   1'b1, ST_ANSWER,   VMAX},
		'{CMD_INSERT, 31'h55555555,   31'd0,          1'b0, ST_INSERTED, 31'd0},
		'{CMD_INSERT, 31'h2AAAAAAA,   31'd0,          1'b0, ST_INSERTED, 31'd0},
		'{CMD_QUERY,  31'h55555555,   31'h55555555,   1'b0, ST_ANSWER,   31'd0},
		'{CMD_QUERY,  31'h2AAAAAAA,   31'h2AAAAAAA,   1'b0, ST_ANSWER,   31'd0},
		'{CMD_QUERY,  31'h2AAAAAAA,   31'h2AAAAAA9,   1'b0, ST_ANSWER,   31'd0},
		// duplicate entry
		'{CMD_INSERT, 31'h55555555,   31'd0,          1'b0, ST_INSERTED, 31'd0},
		'{CMD_QUERY,  31'h01234567,   VMAX,           1'b0, ST_ANSWER,   31'd0},
		'{CMD_INSERT, 31'd1,          31'd0,          1'b0, ST_INSERTED, 31'd0},
		'{CMD_INSERT, 31'h40000000,   31'd0,          1'b0, ST_INSERTED, 31'd0},
		'{CMD_QUERY,  31'h3FFFFFFF,   31'h40000000,   1'b0, ST_ANSWER,   31'd0},
		'{CMD_QUERY,  31'h3FFFFFFF,   31'h3FFFFFFF,   1'b0, ST_ANSWER,   31'd0},
		'{CMD_INSERT, VMAX - 31'd1,   VMAX,           1'b0, ST_INSERTED, 31'd0},
		'{CMD_QUERY,  31'd1,          VMAX,           1'b0, ST_ANSWER,   31'd0}
	};

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [STATUS_BITS-1:0] m_tuser;

	logic [VB-1:0] held_vals [CAPACITY];
	int            held_count;
	xor_result_t   expected_results [$];
	int            errors;
	int            src_idle_pct;
	int            rx_idle_pct;
	bit            long_hold_req;

	bounded_max_xor_query DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	function automatic xor_result_t store_or_query(logic cmd, logic [VB-1:0] key,
			logic [VB-1:0] lim);
		xor_result_t   r;
		logic          found;
		logic [VB-1:0] x;
		r.status = ST_INSERTED;
		r.best_xor = '0;
		found = 1'b0;
		if (cmd == CMD_INSERT) begin
			if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				held_vals[held_count] = key;
				held_count++;
			end
		end else begin
			for (int i = 0; i < held_count; i++) begin
				if (held_vals[i] <= lim) begin
					x = held_vals[i] ^ key;
					if (!found || x > r.best_xor)
						r.best_xor = x;
					found = 1'b1;
				end
			end
			r.status = found ? ST_ANSWER : ST_NONE;
		end
		return r;
	endfunction

	function automatic logic [VB-1:0] rand_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 45)
			return VB'($urandom);
		else if (sel < 65)
			return VB'($urandom_range(1023));
		else if (sel < 80)
			return VMAX - VB'($urandom_range(255));
		else if (sel < 90 && held_count > 0)
			return held_vals[$urandom_range(held_count - 1)];
		else
			return VB'(32'd1 << $urandom_range(VB - 1));
	endfunction

	function automatic logic [VB-1:0] rand_key();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60 || held_count == 0)
			return VB'($urandom);
		else if (sel < 80)
			return held_vals[$urandom_range(held_count - 1)];
		else
			return ~held_vals[$urandom_range(held_count - 1)];
	endfunction

	function automatic logic [VB-1:0] rand_limit();
		int unsigned sel;
		logic [VB-1:0] pick;
		sel = $urandom_range(99);
		pick = (held_count > 0) ? held_vals[$urandom_range(held_count - 1)] : '0;
		if (sel < 20)
			return VMAX;
		else if (sel < 50)
			return VB'($urandom);
		else if (sel < 75)
			return pick;
		else if (sel < 85)
			return pick - 1'b1;
		else
			return VB'($urandom_range(255));
	endfunction

	// Offer one word and hold it until taken; predict at the accepting edge.
	task automatic offer_word(logic cmd, logic [VB-1:0] val, logic [VB-1:0] lim,
			logic fixed = 1'b0, xor_result_t fixed_result = '0);
		logic [IN_W-1:0] word;
		xor_result_t     predicted;
		word = '0;
		word[VB-1:0] = val;
		word[2*VB-1:VB] = lim;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		predicted = store_or_query(cmd, val, lim);
		if (fixed)
			predicted = fixed_result;
		expected_results = {expected_results, predicted};
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic rand_cmd();
		return ($urandom_range(99) < 35) ? CMD_QUERY : CMD_INSERT;
	endfunction

	initial begin : stimulus
		xor_result_t   fixed_result;
		logic          cmd;
		logic [VB-1:0] val;
		logic [VB-1:0] lim;
		errors = 0;
		held_count = 0;
		long_hold_req = 1'b0;
		src_idle_pct = 10;
		rx_idle_pct = 77;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_INSERT;
		s_tdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < SCRIPT_LEN; r++) begin
			fixed_result.status = SCRIPT[r].status;
			fixed_result.best_xor = SCRIPT[r].best_xor;
			offer_word(SCRIPT[r].cmd, SCRIPT[r].val, SCRIPT[r].lim, SCRIPT[r].fixed,
				fixed_result);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				src_idle_pct = 77;
				rx_idle_pct = 10;
			end
			if (n == 2 * RAND_ITEMS / 3) begin
				src_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// back up the output so the input stalls
			if (n == 60)
				long_hold_req = 1'b1;
			if (n == 300)
				drain_results();
			cmd = rand_cmd();
			val = (cmd == CMD_QUERY) ? rand_key() : rand_value();
			lim = rand_limit();
			offer_word(cmd, val, lim);
		end

		// alternate inserts and queries, the last query with a zero limit
		for (int n = 0; n < 8; n++) begin
			cmd = (n % 2 == 0) ? CMD_INSERT : CMD_QUERY;
			val = (cmd == CMD_QUERY) ? rand_key() : rand_value();
			lim = (n == 7) ? '0 : rand_limit();
			offer_word(cmd, val, lim);
		end

		drain_results();
		repeat (CAPACITY + 8) @(posedge clk);
		if (errors == 0)
			$display("bounded_max_xor_query_tb: clean");
		else
			$display("bounded_max_xor_query_tb: errors");
		$finish;
	end

	initial begin : result_check
		int          hold_left;
		xor_result_t want;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", 32'(m_tdata[VB-1:0]), '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[VB-1:0] !== want.best_xor)
						report_mismatch("best_xor", 32'(m_tdata[VB-1:0]),
							32'(want.best_xor));
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = HOLD_STRETCH;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("bounded_max_xor_query_tb: errors");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
design/bmxq_pkg.sv
design/bmxq_best.sv
design/bounded_max_xor_query.sv
design/bmxq_check.sv
sim/bounded_max_xor_query_tb.sv
